// ===== rtl/core/udta_pkg.sv =====
// udta_pkg: shared types, constants and character tables for the utf-8 to ascii normaliser
// used by udta_front, udta_fifo, udta_back and the top level; no dependencies

package udta_pkg;

  // mode register values; mode 3 behaves as transliterate only
  localparam logic [1:0] ModeXlat  = 2'd0;
  localparam logic [1:0] ModeUpper = 2'd1;
  localparam logic [1:0] ModeLower = 2'd2;

  // default depth of the queue between front and back
  localparam int unsigned FifoDepth = 4;

  // one queue entry: all results caused by one input byte
  typedef struct packed {
    logic [2:0][6:0] chars;        // up to three characters, first in slot 0
    logic [1:0]      last_idx;     // slot of the final result
    logic            char_valid;   // 0 for a bare end marker
    logic            string_done;  // entry belongs to the last byte of a string
  } udta_entry_t;

  // transliteration of one code point: up to two characters
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0][6:0] chr;
  } udta_xlat_t;

  // code point to ascii lookup
  function automatic udta_xlat_t xlat(input logic [20:0] v);
    udta_xlat_t r;
    logic       low;
    logic [7:0] c;
    logic [6:0] add;
    r   = '0;
    low = (v[7:0] >= 8'hE0);
    c   = v[7:0] & 8'hDF;
    add = low ? 7'd32 : 7'd0;
    if (v < 21'h7F) begin
      r.cnt = 2'd1; r.chr[0] = v[6:0];
    end else if (v >= 21'hC0 && v <= 21'hFF) begin
      // latin-1 block: small-letter half folded onto the capital half
      if (c <= 8'hC5) begin
        r.cnt = 2'd1; r.chr[0] = 7'h41 + add;
      end else if (c == 8'hC6) begin
        r.cnt = 2'd2; r.chr[0] = 7'h41 + add; r.chr[1] = 7'h45 + add;
      end else if (c == 8'hC7) begin
        r.cnt = 2'd1; r.chr[0] = 7'h43 + add;
      end else if (c <= 8'hCB) begin
        r.cnt = 2'd1; r.chr[0] = 7'h45 + add;
      end else if (c <= 8'hCF) begin
        r.cnt = 2'd1; r.chr[0] = 7'h49 + add;
      end else if (c == 8'hD0 || c == 8'hDE) begin
        r.cnt = 2'd2; r.chr[0] = 7'h54 + add; r.chr[1] = 7'h48 + add;
      end else if (c == 8'hD1) begin
        r.cnt = 2'd1; r.chr[0] = 7'h4E + add;
      end else if (c <= 8'hD6 || c == 8'hD8) begin
        r.cnt = 2'd1; r.chr[0] = 7'h4F + add;
      end else if (c == 8'hD7) begin
        // multiplication and division signs
        r.cnt = 2'd1; r.chr[0] = low ? 7'h2F : 7'h2A;
      end else if (c <= 8'hDC) begin
        r.cnt = 2'd1; r.chr[0] = 7'h55 + add;
      end else if (c == 8'hDD) begin
        r.cnt = 2'd1; r.chr[0] = 7'h59 + add;
      end else if (low) begin
        // y with diaeresis
        r.cnt = 2'd1; r.chr[0] = 7'h79;
      end else begin
        // sharp s
        r.cnt = 2'd2; r.chr[0] = 7'h73; r.chr[1] = 7'h73;
      end
    end else begin
      // capital sharp s and the romanian letters
      case (v)
        21'h1E9E: begin r.cnt = 2'd2; r.chr[0] = 7'h53; r.chr[1] = 7'h53; end
        21'h102:  begin r.cnt = 2'd1; r.chr[0] = 7'h41; end
        21'h103:  begin r.cnt = 2'd1; r.chr[0] = 7'h61; end
        21'h218, 21'h15E: begin r.cnt = 2'd1; r.chr[0] = 7'h53; end
        21'h219, 21'h15F: begin r.cnt = 2'd1; r.chr[0] = 7'h73; end
        21'h21A, 21'h162: begin r.cnt = 2'd1; r.chr[0] = 7'h54; end
        21'h21B, 21'h163: begin r.cnt = 2'd1; r.chr[0] = 7'h74; end
        default: r.cnt = 2'd0;
      endcase
    end
    return r;
  endfunction

  // word separators: control characters, space and the operator set
  function automatic logic is_sep(input logic [6:0] c);
    logic s;
    s = (c <= 7'd32);
    case (c) inside
      7'h3B, 7'h3A, 7'h2D, 7'h2C, 7'h2E, 7'h3D, 7'h29, 7'h28,
      7'h3C, 7'h3E, 7'h5B, 7'h5D, 7'h7B, 7'h7D, 7'h2F, 7'h26,
      7'h25, 7'h2A, 7'h7C, 7'h2B, 7'h23, 7'h3F, 7'h21, 7'h24: s = 1'b1;
      default: ;
    endcase
    return s;
  endfunction

  // letters, digits and underscore
  function automatic logic is_word(input logic [6:0] c);
    return (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
           (c >= 7'h61 && c <= 7'h7A) || (c == 7'h5F);
  endfunction

endpackage

// ===== rtl/core/udta_front.sv =====
// udta_front: utf-8 decoder, transliteration and name filter
// builds at most one queue entry per accepted byte; depends on udta_pkg

module udta_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 eos_i,
  output logic                 push_o,
  output udta_pkg::udta_entry_t entry_o
);

  logic [1:0]  mode_q;
  logic [20:0] acc_q, acc_d, acc_nx;
  logic [1:0]  rem_q, rem_d;
  logic        space_q, space_d;
  logic        word_q, word_d;
  logic        nul_q, nul_d;
  logic        have;
  logic [20:0] cp;
  logic        name_mode;
  logic [1:0]  n;
  logic [6:0]  c;
  logic [2:0][6:0] chars;
  udta_pkg::udta_xlat_t xl;

  assign name_mode = (mode_q == udta_pkg::ModeUpper) || (mode_q == udta_pkg::ModeLower);

  // decode, transliterate and filter one byte
  always_comb begin
    acc_d   = acc_q;
    rem_d   = rem_q;
    nul_d   = nul_q;
    space_d = space_q;
    word_d  = word_q;
    have    = 1'b0;
    cp      = '0;
    acc_nx  = {acc_q[14:0], in_byte_i[5:0]};
    c       = '0;
    if (!nul_q) begin
      if (in_byte_i == 8'h00) begin
        nul_d = 1'b1; rem_d = 2'd0; acc_d = '0;
      end else if (!in_byte_i[7]) begin
        rem_d = 2'd0; acc_d = '0; cp = {14'd0, in_byte_i[6:0]}; have = 1'b1;
      end else if (in_byte_i[7:6] == 2'b10) begin
        // continuation byte, dropped when no sequence is open
        if (rem_q != 2'd0) begin
          acc_d = acc_nx;
          rem_d = rem_q - 2'd1;
          if (rem_q == 2'd1) begin
            cp = acc_nx; have = 1'b1; acc_d = '0;
          end
        end
      end else if (in_byte_i[7:5] == 3'b110) begin
        acc_d = {16'd0, in_byte_i[4:0]}; rem_d = 2'd1;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        acc_d = {17'd0, in_byte_i[3:0]}; rem_d = 2'd2;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        acc_d = {18'd0, in_byte_i[2:0]}; rem_d = 2'd3;
      end else begin
        acc_d = '0; rem_d = 2'd0;
      end
    end

    xl    = udta_pkg::xlat(cp);
    chars = '0;
    n     = 2'd0;
    // at most two characters per code point
    for (int i = 0; i < 2; i++) begin
      if (have && (2'(i) < xl.cnt)) begin
        c = xl.chr[1'(i)];
        if (!name_mode) begin
          chars[n] = c; n = n + 2'd1;
        end else if (udta_pkg::is_sep(c)) begin
          if (word_d) space_d = 1'b1;
        end else if (udta_pkg::is_word(c)) begin
          if (space_d) begin
            chars[n] = 7'h20; n = n + 2'd1; space_d = 1'b0;
          end
          if (mode_q == udta_pkg::ModeUpper && c >= 7'h61 && c <= 7'h7A) c = c - 7'd32;
          if (mode_q == udta_pkg::ModeLower && c >= 7'h41 && c <= 7'h5A) c = c + 7'd32;
          chars[n] = c; n = n + 2'd1; word_d = 1'b1;
        end
      end
    end

    // end of string clears all decoder and word state
    if (eos_i) begin
      acc_d = '0; rem_d = 2'd0; space_d = 1'b0; word_d = 1'b0; nul_d = 1'b0;
    end
  end

  // queue entry
  always_comb begin
    entry_o.chars       = chars;
    entry_o.char_valid  = (n != 2'd0);
    entry_o.last_idx    = (n == 2'd0) ? 2'd0 : n - 2'd1;
    entry_o.string_done = eos_i;
  end

  assign push_o = accept_i && ((n != 2'd0) || eos_i);

  // state registers: mode on a config write, decoder and word state per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= udta_pkg::ModeXlat;
      acc_q   <= '0;
      rem_q   <= '0;
      space_q <= 1'b0;
      word_q  <= 1'b0;
      nul_q   <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (accept_i) begin
        acc_q   <= acc_d;
        rem_q   <= rem_d;
        space_q <= space_d;
        word_q  <= word_d;
        nul_q   <= nul_d;
      end
    end
  end

endmodule

// ===== rtl/core/udta_fifo.sv =====
// udta_fifo: short queue of per-byte result entries between front and back
// depends on udta_pkg for the entry type

module udta_fifo #(
  parameter int unsigned Depth = udta_pkg::FifoDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  udta_pkg::udta_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output udta_pkg::udta_entry_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  udta_pkg::udta_entry_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_ptr_q] <= push_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + AW'(1);
      if (pop_i && !empty_o) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + AW'(1);
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/udta_back.sv =====
// udta_back: splits queue entries into single results and holds the output register
// depends on udta_pkg for the entry type

module udta_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  empty_i,
  input  udta_pkg::udta_entry_t head_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [6:0]            out_char_o,
  output logic                  char_valid_o,
  output logic                  string_done_o,
  output logic                  run_last_o
);

  logic [1:0] idx_q;
  logic       load, at_last;
  logic       valid_q;
  logic [6:0] char_q;
  logic       cv_q, done_q, last_q;

  assign load    = !empty_i && (!valid_q || ready_i);
  assign at_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && at_last;

  // slot counter within the head entry and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
      if (load) valid_q <= 1'b1;
      else if (ready_i) valid_q <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      cv_q   <= head_i.char_valid;
      done_q <= head_i.string_done && at_last;
      last_q <= at_last;
    end
  end

  assign valid_o       = valid_q;
  assign out_char_o    = char_q;
  assign char_valid_o  = cv_q;
  assign string_done_o = done_q;
  assign run_last_o    = last_q;

endmodule

// ===== rtl/core/utf8_diacritic_to_ascii_normalizer_top.sv =====
// utf8_diacritic_to_ascii_normalizer_top: utf-8 byte stream to ascii characters
// instantiates udta_front, udta_fifo and udta_back; depends on udta_pkg
//
// Usage:
//   Input stream: one utf-8 byte per transaction on s_axis_tdata, s_axis_tlast set on
//   the final byte of a string. Output stream: one ascii character per transaction on
//   m_axis_tdata[6:0]; m_axis_tuser[0] is 0 for a bare end marker (a final byte that
//   yields no character), m_axis_tuser[1] flags the last result of a string, and
//   m_axis_tlast flags the last result caused by one input byte.
//   The mode register (cfg_wdata_i on cfg_we_i) selects plain transliteration (0),
//   upper-case name normalisation (1) or lower-case name normalisation (2); write it
//   only while the block is idle.
//   The first result of a byte passes through the queue and then the output register
//   before its output transaction can complete. A byte is accepted every cycle while
//   the queue between decoder and output stage has room; a byte gives at most three
//   results, and the sustained rate is one result per cycle while the receiver is
//   ready, set by the single output register. Bytes that yield nothing take no queue
//   slot.
//   Reset clears the decoder, the word state, the queue and the mode (to 0).
//   When the receiver stalls, the output register holds its result, the queue
//   fills, and s_axis_tready drops once the queue is full.

module utf8_diacritic_to_ascii_normalizer_top #(
  parameter int unsigned FifoDepth = udta_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_string
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic [1:0] m_axis_tuser,   // [0] char_valid, [1] string_done
  output logic       m_axis_tlast    // run_last
);

  logic                  accept, push, full, pop, empty;
  udta_pkg::udta_entry_t push_data, head;
  logic [6:0]            out_char;
  logic                  char_valid, string_done, run_last;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  // decoder and filter
  udta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_byte_i   (s_axis_tdata),
    .eos_i       (s_axis_tlast),
    .push_o      (push),
    .entry_o     (push_data)
  );

  // entry queue
  udta_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // result serialiser and output register
  udta_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head),
    .pop_o         (pop),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .out_char_o    (out_char),
    .char_valid_o  (char_valid),
    .string_done_o (string_done),
    .run_last_o    (run_last)
  );

  assign m_axis_tdata = {1'b0, out_char};
  assign m_axis_tuser = {string_done, char_valid};
  assign m_axis_tlast = run_last;

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for utf8_diacritic_to_ascii_normalizer_top
// predicts every output character from the bytes it sends; depends on udta_pkg and the rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // mode 3 is not named in the package and must act as plain transliteration
  localparam logic [1:0] ModeSpare  = 2'd3;
  localparam int         CycleLimit = 200000;
  localparam int         SettleGap  = 8;

  // one output transaction as the checker sees it
  typedef struct packed {
    logic [6:0] ch;
    logic       valid;
    logic       done;
    logic       last;
  } ascii_result_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;
  logic       s_axis_tlast;
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  // decoder and word state of the predictor
  logic [1:0]  mode_q    = udta_pkg::ModeXlat;
  logic [20:0] cp_acc    = '0;
  logic [1:0]  remaining = '0;
  logic        sp_pend   = 1'b0;
  logic        word_seen = 1'b0;
  logic        nul_stop  = 1'b0;

  ascii_result_t expected_chars[$];
  ascii_result_t burst[3];
  int            nburst;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int mismatches   = 0;
  int cycles       = 0;

  utf8_diacritic_to_ascii_normalizer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // code point to ascii: returns the number of characters
  function automatic int to_ascii(input logic [20:0] v, output logic [6:0] c0,
                                  output logic [6:0] c1);
    logic [7:0] up;  // latin-1 code folded onto the capital half
    logic [6:0] cs;  // case offset, 32 for the small half
    c0 = '0;
    c1 = '0;
    up = v[7:0] & 8'hDF;
    cs = (v[7:0] >= 8'hE0) ? 7'd32 : 7'd0;
    if (v < 21'h7F) begin
      c0 = v[6:0];
      return 1;
    end
    if (v >= 21'hC0 && v <= 21'hFF) begin
      // multiplication and division signs
      if (up == 8'hD7) begin
        c0 = (cs != 0) ? 7'h2F : 7'h2A;
        return 1;
      end
      // sharp s and y with diaeresis share a slot
      if (up == 8'hDF) begin
        if (cs != 0) begin
          c0 = 7'h79;
          return 1;
        end
        c0 = 7'h73;
        c1 = 7'h73;
        return 2;
      end
      // ligature ae
      if (up == 8'hC6) begin
        c0 = 7'h41 + cs;
        c1 = 7'h45 + cs;
        return 2;
      end
      // eth and thorn
      if (up == 8'hD0 || up == 8'hDE) begin
        c0 = 7'h54 + cs;
        c1 = 7'h48 + cs;
        return 2;
      end
      if (up <= 8'hC5) c0 = 7'h41;
      else if (up == 8'hC7) c0 = 7'h43;
      else if (up <= 8'hCB) c0 = 7'h45;
      else if (up <= 8'hCF) c0 = 7'h49;
      else if (up == 8'hD1) c0 = 7'h4E;
      else if (up <= 8'hD6 || up == 8'hD8) c0 = 7'h4F;
      else if (up <= 8'hDC) c0 = 7'h55;
      else c0 = 7'h59;
      c0 = c0 + cs;
      return 1;
    end
    // capital sharp s and the romanian letters
    case (v)
      21'h1E9E: begin c0 = 7'h53; c1 = 7'h53; return 2; end
      21'h102: c0 = 7'h41;
      21'h103: c0 = 7'h61;
      21'h218, 21'h15E: c0 = 7'h53;
      21'h219, 21'h15F: c0 = 7'h73;
      21'h21A, 21'h162: c0 = 7'h54;
      21'h21B, 21'h163: c0 = 7'h74;
      default: return 0;
    endcase
    return 1;
  endfunction

  // control characters, space and the operator set split words
  function automatic bit is_word_break(input logic [6:0] c);
    string ops = ";:-,.=)(<>[]{}/&%*|+#?!$";
    if (c <= 7'd32) return 1'b1;
    for (int i = 0; i < ops.len(); i++)
      if (ops[i] == {1'b0, c}) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_name_char(input logic [6:0] c);
    return (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
           (c >= 7'h61 && c <= 7'h7A) || (c == 7'h5F);
  endfunction

  task automatic queue_char(input logic [6:0] c);
    burst[nburst] = '{ch: c, valid: 1'b1, done: 1'b0, last: 1'b0};
    nburst++;
  endtask

  // one transliterated character through the optional name filter
  task automatic take_char(input logic [6:0] c);
    if (mode_q != udta_pkg::ModeUpper && mode_q != udta_pkg::ModeLower) begin
      queue_char(c);
      return;
    end
    if (is_word_break(c)) begin
      if (word_seen) sp_pend = 1'b1;
      return;
    end
    if (!is_name_char(c)) return;
    if (sp_pend) begin
      queue_char(7'h20);
      sp_pend = 1'b0;
    end
    if (mode_q == udta_pkg::ModeUpper && c >= 7'h61 && c <= 7'h7A) c = c - 7'd32;
    if (mode_q == udta_pkg::ModeLower && c >= 7'h41 && c <= 7'h5A) c = c + 7'd32;
    word_seen = 1'b1;
    queue_char(c);
  endtask

  // expected characters for one accepted byte
  task automatic predict_byte(input logic [7:0] b, input logic eos);
    logic        got_cp;
    logic [20:0] cp;
    logic [6:0]  c0;
    logic [6:0]  c1;
    int          nch;
    got_cp = 1'b0;
    cp     = '0;
    nburst = 0;
    if (!nul_stop) begin
      if (b == 8'h00) begin
        nul_stop  = 1'b1;
        remaining = '0;
        cp_acc    = '0;
      end else if (!b[7]) begin
        remaining = '0;
        cp_acc    = '0;
        cp        = {13'b0, b};
        got_cp    = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        // continuation: stray ones are dropped
        if (remaining != 0) begin
          cp_acc    = {cp_acc[14:0], b[5:0]};
          remaining = remaining - 2'd1;
          if (remaining == 0) begin
            cp     = cp_acc;
            got_cp = 1'b1;
            cp_acc = '0;
          end
        end
      end else if (b[7:5] == 3'b110) begin
        cp_acc    = {16'b0, b[4:0]};
        remaining = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc    = {17'b0, b[3:0]};
        remaining = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc    = {18'b0, b[2:0]};
        remaining = 2'd3;
      end else begin
        cp_acc    = '0;
        remaining = '0;
      end
    end
    if (got_cp) begin
      nch = to_ascii(cp, c0, c1);
      if (nch > 0) take_char(c0);
      if (nch > 1) take_char(c1);
    end
    // end of string: bare marker if nothing came out, then a fresh start
    if (eos) begin
      if (nburst == 0) begin
        burst[0] = '0;
        nburst   = 1;
      end
      burst[nburst-1].done = 1'b1;
      cp_acc    = '0;
      remaining = '0;
      sp_pend   = 1'b0;
      word_seen = 1'b0;
      nul_stop  = 1'b0;
    end
    if (nburst > 0) burst[nburst-1].last = 1'b1;
    for (int i = 0; i < nburst; i++) expected_chars.insert(expected_chars.size(), burst[i]);
  endtask

  task automatic flag_mismatch(input string what, input ascii_result_t want,
                               input ascii_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected char %h valid %b done %b last %b, got char %h valid %b done %b last %b",
               $realtime, what, want.ch, want.valid, want.done, want.last,
               got.ch, got.valid, got.done, got.last);
  endtask

  // output checker
  always @(posedge clk_i) begin : check_output
    ascii_result_t want;
    ascii_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{ch: m_axis_tdata[6:0], valid: m_axis_tuser[0], done: m_axis_tuser[1],
              last: m_axis_tlast};
      if (expected_chars.size() == 0) begin
        flag_mismatch("unexpected transaction", '0, got);
      end else begin
        want = expected_chars.pop_front();
        if (got !== want) flag_mismatch("wrong transaction", want, got);
        else if (m_axis_tdata[7] !== 1'b0) flag_mismatch("padding bit set", want, got);
      end
    end
  end

  // one byte on the input stream; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, eos);
  endtask

  task automatic send_string(input logic [7:0] text[$]);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  // drop valid and wait until every expected character is out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_q = m;
  endtask

  // latin-1 ligature ae, capital sharp s, s with cedilla, division sign
  task automatic test_transliteration();
    set_mode(udta_pkg::ModeXlat);
    send_string('{8'hC3, 8'h86, 8'hE1, 8'hBA, 8'h9E, 8'hC5, 8'h9E, 8'hC3, 8'hB7, 8'h7E});
  endtask

  // stray continuation, restart inside a sequence, invalid lead, overlong,
  // dropped 0x7f and a string that ends inside a sequence
  task automatic test_malformed_input();
    send_string('{8'h80, 8'hC3, 8'h41, 8'hFF, 8'hC1, 8'h81, 8'h7F, 8'hE2, 8'h82});
  endtask

  // zero byte stops the string, in the unused mode value
  task automatic test_nul_stop();
    set_mode(ModeSpare);
    send_string('{8'h42, 8'h00, 8'hC3, 8'h61});
  endtask

  // separators collapse, edges trimmed, mode switch in the middle of a string
  task automatic test_name_normalisation();
    set_mode(udta_pkg::ModeUpper);
    send_string('{8'h20, 8'h61, 8'h2D, 8'h2C, 8'hC3, 8'hA9, 8'h21});
    send_byte(8'h5F, 1'b0);
    send_byte(8'h20, 1'b0);
    set_mode(udta_pkg::ModeLower);
    send_string('{8'hC3, 8'h97, 8'h51});
  endtask

  // one string of random but mostly well formed content
  task automatic send_random_string(output int nbytes);
    logic [7:0]  text[$];
    logic [20:0] cp;
    int          pick;
    string       ops;
    ops = ";:-,.=)(<>[]{}/&%*|+#?!$";
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        text.insert(text.size(), 8'($urandom_range(33, 126)));
      end else if (pick < 34) begin
        text.insert(text.size(), ops[$urandom_range(ops.len() - 1)]);
      end else if (pick < 40) begin
        text.insert(text.size(), 8'($urandom_range(1, 32)));
      end else if (pick < 60) begin
        text.insert(text.size(), 8'hC3);
        text.insert(text.size(), {2'b10, 6'($urandom_range(63))});
      end else if (pick < 70) begin
        case ($urandom_range(10))
          0: cp = 21'h102;
          1: cp = 21'h103;
          2: cp = 21'h15E;
          3: cp = 21'h15F;
          4: cp = 21'h162;
          5: cp = 21'h163;
          6: cp = 21'h218;
          7: cp = 21'h219;
          8: cp = 21'h21A;
          9: cp = 21'h21B;
          default: cp = 21'h1E9E;
        endcase
        if (cp < 21'h800) begin
          text.insert(text.size(), {3'b110, cp[10:6]});
        end else begin
          text.insert(text.size(), {4'b1110, cp[15:12]});
          text.insert(text.size(), {2'b10, cp[11:6]});
        end
        text.insert(text.size(), {2'b10, cp[5:0]});
      end else if (pick < 78) begin
        // other three and four byte sequences
        if (pick < 74) begin
          text.insert(text.size(), {4'b1110, 4'($urandom_range(15))});
        end else begin
          text.insert(text.size(), {5'b11110, 3'($urandom_range(7))});
          text.insert(text.size(), {2'b10, 6'($urandom_range(63))});
        end
        text.insert(text.size(), {2'b10, 6'($urandom_range(63))});
        text.insert(text.size(), {2'b10, 6'($urandom_range(63))});
      end else if (pick < 86) begin
        // any two byte sequence, overlong ones included
        text.insert(text.size(), {3'b110, 5'($urandom_range(31))});
        text.insert(text.size(), {2'b10, 6'($urandom_range(63))});
      end else if (pick < 88) begin
        text.insert(text.size(), 8'h00);
      end else begin
        text.insert(text.size(), 8'($urandom_range(255)));
      end
    end
    send_string(text);
    nbytes = text.size();
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int nbytes);
    int sent;
    int nb;
    int strings;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent    = 0;
    strings = 0;
    while (sent < nbytes) begin
      if (strings % 3 == 0) set_mode(2'($urandom_range(3)));
      send_random_string(nb);
      sent += nb;
      strings++;
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(6, 79, 45);
    run_random_phase(79, 6, 45);
    run_random_phase(0, 0, 45);
  endtask

  // sequence of tests
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= udta_pkg::ModeXlat;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_transliteration();
    test_malformed_input();
    test_nul_stop();
    test_name_normalisation();
    test_random_traffic();
    settle();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/udta_pkg.sv
rtl/core/udta_front.sv
rtl/core/udta_fifo.sv
rtl/core/udta_back.sv
rtl/core/utf8_diacritic_to_ascii_normalizer_top.sv
tb/testbench.sv
